@@ rtl/core/deq_pkg.sv @@
// deq_pkg: shared types and constants for the double-ended queue core
// no dependencies; used by deq_front, deq_back and double_ended_queue_core
package deq_pkg;

	localparam int DEPTH_DEFAULT   = 16;
	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int RES_QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_DUMP       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic               is_push;
		logic               at_front;
		logic               is_pop;
		logic               is_dump;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] data;
		logic               last;
	} res_t;

endpackage

@@ rtl/core/deq_fifo.sv @@
// deq_fifo: small register-based first-in first-out queue
// generic width and depth; no package dependencies
module deq_fifo #(
	parameter int W = 8,
	parameter int D = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [W-1:0]           din,
	output logic                   full,
	input  logic                   pop,
	output logic [W-1:0]           dout,
	output logic                   empty,
	output logic [$clog2(D+1)-1:0] count
);

	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	logic [W-1:0]  mem_q [D];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(D));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/deq_front.sv @@
// deq_front: accepts input items, decodes the operation, queues commands
// depends on deq_pkg and deq_fifo
module deq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  value,
	input  logic                cmd_pop,
	output deq_pkg::cmd_t       cmd,
	output logic                cmd_empty
);

	localparam int CQ_CW = $clog2(deq_pkg::CMD_QUEUE_DEPTH + 1);

	deq_pkg::cmd_t      dec;
	logic [CQ_CW-1:0]   cq_count;
	logic [$bits(deq_pkg::cmd_t)-1:0] cq_dout;

	always_comb begin
		dec = '0;
		case (deq_pkg::op_t'(operation))
			deq_pkg::OP_PUSH_FRONT: begin
				dec.is_push  = 1'b1;
				dec.at_front = 1'b1;
				dec.value    = value;
			end
			deq_pkg::OP_PUSH_BACK: begin
				dec.is_push = 1'b1;
				dec.value   = value;
			end
			deq_pkg::OP_POP_FRONT: begin
				dec.is_pop = 1'b1;
			end
			deq_pkg::OP_DUMP: begin
				dec.is_dump = 1'b1;
			end
			default: begin
				dec = '0;
			end
		endcase
	end

	deq_fifo #(
		.W ($bits(deq_pkg::cmd_t)),
		.D (deq_pkg::CMD_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (dec),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cq_dout),
		.empty  (cmd_empty),
		.count  (cq_count)
	);

	assign cmd = deq_pkg::cmd_t'(cq_dout);

	logic unused_count;
	assign unused_count = ^cq_count;

endmodule

@@ rtl/core/deq_back.sv @@
// deq_back: executes queued commands on the ring buffer and issues results
// depends on deq_pkg; holds the value store and the front index and occupancy
module deq_back #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  deq_pkg::cmd_t                               cmd,
	input  logic                                        cmd_empty,
	output logic                                        cmd_pop,
	input  logic [$clog2(deq_pkg::RES_QUEUE_DEPTH+1)-1:0] oq_count,
	output logic                                        res_push,
	output deq_pkg::res_t                               res
);

	localparam int AW    = $clog2(DEPTH);
	localparam int OW    = $clog2(DEPTH + 1);
	localparam int SW    = OW + 1;
	localparam int OQ_CW = $clog2(deq_pkg::RES_QUEUE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t state_q;
	logic [AW-1:0] front_q;
	logic [OW-1:0] occ_q;
	logic [AW-1:0] ptr_q;
	logic [OW-1:0] cnt_q;

	logic               vld_s1;
	deq_pkg::status_t   status_s1;
	logic               last_s1;
	logic               mem_s1;
	logic signed [31:0] rd_data_s1;

	logic signed [31:0] mem_q [DEPTH];

	logic               room;
	logic               issue;
	deq_pkg::status_t   iss_status;
	logic               iss_last;
	logic               iss_mem;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	state_t             state_d;
	logic [AW-1:0]      front_d;
	logic [OW-1:0]      occ_d;
	logic [AW-1:0]      ptr_d;
	logic [OW-1:0]      cnt_d;
	logic [SW-1:0]      back_sum;
	logic [AW-1:0]      back_addr;
	logic [AW-1:0]      front_inc;
	logic [AW-1:0]      front_dec;
	logic [AW-1:0]      ptr_inc;
	logic               is_full;
	logic               is_empty;

	assign room = ({1'b0, oq_count} + (OQ_CW+1)'(vld_s1))
		<= (OQ_CW+1)'(deq_pkg::RES_QUEUE_DEPTH - 1);

	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign ptr_inc   = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign back_sum  = SW'(front_q) + SW'(occ_q);
	assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
		: AW'(back_sum);
	assign is_full   = (occ_q == OW'(DEPTH));
	assign is_empty  = (occ_q == '0);

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		occ_d      = occ_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		cmd_pop    = 1'b0;
		issue      = 1'b0;
		iss_status = deq_pkg::ST_OK;
		iss_last   = 1'b1;
		iss_mem    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = back_addr;
		rd_en      = 1'b0;
		rd_addr    = front_q;
		case (state_q)
			S_IDLE: begin
				if (!cmd_empty && room) begin
					cmd_pop = 1'b1;
					issue   = 1'b1;
					if (cmd.is_push) begin
						if (is_full) begin
							iss_status = deq_pkg::ST_FULL;
						end else begin
							wr_en = 1'b1;
							occ_d = occ_q + 1'b1;
							if (cmd.at_front) begin
								wr_addr = front_dec;
								front_d = front_dec;
							end
						end
					end else if (cmd.is_pop) begin
						if (is_empty) begin
							iss_status = deq_pkg::ST_EMPTY;
						end else begin
							rd_en   = 1'b1;
							iss_mem = 1'b1;
							front_d = front_inc;
							occ_d   = occ_q - 1'b1;
						end
					end else begin
						if (is_empty) begin
							iss_status = deq_pkg::ST_EMPTY;
						end else begin
							// first entry of the walk goes out now
							rd_en    = 1'b1;
							iss_mem  = 1'b1;
							iss_last = (occ_q == OW'(1));
							ptr_d    = front_inc;
							cnt_d    = occ_q - 1'b1;
							if (occ_q != OW'(1)) begin
								state_d = S_DUMP;
							end
						end
					end
				end
			end
			S_DUMP: begin
				rd_addr = ptr_q;
				if (room) begin
					issue    = 1'b1;
					rd_en    = 1'b1;
					iss_mem  = 1'b1;
					iss_last = (cnt_q == OW'(1));
					ptr_d    = ptr_inc;
					cnt_d    = cnt_q - 1'b1;
					if (cnt_q == OW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		if (issue) begin
			status_s1 <= iss_status;
			last_s1   <= iss_last;
			mem_s1    <= iss_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			occ_q   <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			ptr_q   <= ptr_d;
			cnt_q   <= cnt_d;
			vld_s1  <= issue;
		end
	end

	assign res_push    = vld_s1;
	assign res.status  = status_s1;
	assign res.data    = mem_s1 ? rd_data_s1 : 32'sd0;
	assign res.last    = last_s1;

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1))
		else $error("front index out of range");

	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> cnt_q != '0 && cnt_q <= occ_q)
		else $error("dump walk count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> oq_count < OQ_CW'(deq_pkg::RES_QUEUE_DEPTH))
		else $error("result issued into a full result queue");

	a_dump_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |=> $stable(occ_q) && $stable(front_q))
		else $error("queue state changed during dump");
`endif

endmodule

@@ rtl/core/double_ended_queue_core.sv @@
// double_ended_queue_core: top level of the bounded double-ended queue
// depends on deq_pkg, deq_front, deq_back and deq_fifo
//
// Usage:
//   Input channel: drive operation and value, raise push; the item is taken
//   at a clock edge where push is high and full is low.
//   Result channel: while empty is low the oldest result is on status, data
//   and last; raise pop to take it.
//   Push front, push back and pop give one result each with last set. Dump
//   gives one result per stored value, front to back, last on the back one;
//   on an empty queue it gives a single empty result.
// Path: when both queues are empty, a taken item goes through the command
//   queue, the execution register and the result queue to the result ports.
// Throughput: one item per cycle for pushes and pops while pop keeps up;
//   a dump reads stored values in turn via the value store's single read port.
// Reset: arst_n clears the queue to empty and drops all waiting items and
//   results; no clearing pass is needed.
// Stall: when pop stays low the result queue fills, execution halts, the
//   command queue fills and full rises.
module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [31:0] data,
	output logic               last
);

	localparam int OQ_CW = $clog2(deq_pkg::RES_QUEUE_DEPTH + 1);

	deq_pkg::cmd_t  cmd;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           res_push;
	deq_pkg::res_t  res;
	deq_pkg::res_t  res_out;
	logic           oq_full;
	logic [OQ_CW-1:0] oq_count;
	logic [$bits(deq_pkg::res_t)-1:0] oq_dout;

	deq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.value     (value),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	deq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.oq_count  (oq_count),
		.res_push  (res_push),
		.res       (res)
	);

	deq_fifo #(
		.W ($bits(deq_pkg::res_t)),
		.D (deq_pkg::RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (oq_full),
		.pop    (pop),
		.dout   (oq_dout),
		.empty  (empty),
		.count  (oq_count)
	);

	assign res_out = deq_pkg::res_t'(oq_dout);
	assign status  = res_out.status;
	assign data    = res_out.data;
	assign last    = res_out.last;

	logic unused_full;
	assign unused_full = oq_full;

endmodule
